FILE: design/efr_pkg.sv
// Shared types, constants and the CRC-16 byte update for the escaped frame receiver.
// No dependencies; imported by every module of the block.
package efr_pkg;

    localparam int STORE_DEPTH = 512;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W       = 9;
    localparam int CMP_W       = ((LEN_W > IDX_W) ? LEN_W : IDX_W) + 1;

    localparam logic [1:0] FUNC_PUSH    = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;

    localparam logic [1:0] REG_START_CODE  = 2'd0;
    localparam logic [1:0] REG_END_CODE    = 2'd1;
    localparam logic [1:0] REG_ESCAPE_CODE = 2'd2;

    localparam logic [7:0] START_CODE_RST  = 8'h01;
    localparam logic [7:0] END_CODE_RST    = 8'h04;
    localparam logic [7:0] ESCAPE_CODE_RST = 8'h10;

    typedef enum logic [2:0] {
        EV_ABSORBED = 3'd0,
        EV_GOOD     = 3'd1,
        EV_BAD      = 3'd2,
        EV_DROPPED  = 3'd3,
        EV_READ     = 3'd4,
        EV_RELEASED = 3'd5
    } event_t;

    typedef struct packed {
        event_t      ev;
        logic        held;
        logic [9:0]  length;
        logic        rd_ok;
        logic [15:0] crc;
        logic [15:0] tail;
    } stage_t;

    localparam logic [15:0] NIB_TAB [16] = '{
        16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50a5, 16'h60c6, 16'h70e7,
        16'h8108, 16'h9129, 16'ha14a, 16'hb16b, 16'hc18c, 16'hd1ad, 16'he1ce, 16'hf1ef
    };

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = NIB_TAB[crc[15:12] ^ b[7:4]] ^ {crc[11:0], 4'h0};
        c = NIB_TAB[c[15:12] ^ b[3:0]] ^ {c[11:0], 4'h0};
        return c;
    endfunction

endpackage

FILE: design/escaped_frame_receiver_crc16_core.sv
// Top level of the escaped frame receiver with CRC-16 frame check.
// Depends on efr_pkg, efr_store_ram, efr_rx_ctrl and efr_out_pipe.
//
// Usage:
//   Input words arrive on item_valid/item_ready with func, rx_byte and read_index.
//   func selects push of a line byte, read of a stored byte, or release of a held frame.
//   Each input word produces exactly one result word on result_valid/result_ready.
//   The start, end and escape codes are written through cfg_write, cfg_index and
//   cfg_data while the block is idle; a write takes effect at the next clock edge.
//   From acceptance to result_valid a word passes the first stage register, which
//   takes the state update and the store access, and then the output register.
//   Throughput is one word per cycle while result_ready is high; the per-byte CRC update
//   runs two nibble table steps in the same cycle, and the RAM registers its read data.
//   When the receiver stalls, the output register holds its word and the first stage
//   holds the next one; item_ready drops only when both are full.
//   Reset restores the default codes, empties the frame, clears the escape and held
//   flags and the CRC. The store contents are not cleared; entries are only read
//   below the current length, so no clearing pass is needed.
module escaped_frame_receiver_crc16_core
    import efr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic             item_valid,
    output logic             item_ready,
    input  logic [1:0]       func,
    input  logic [7:0]       rx_byte,
    input  logic [IDX_W-1:0] read_index,
    output logic             result_valid,
    input  logic             result_ready,
    output logic [2:0]       event_res,
    output logic             frame_held,
    output logic [9:0]       frame_length,
    output logic [7:0]       read_data,
    output logic [15:0]      computed_crc,
    output logic [15:0]      received_crc
);

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    stage_t            stage;
    logic              stage_valid;
    logic              stage_take;

    efr_store_ram u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    efr_rx_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .func        (func),
        .rx_byte     (rx_byte),
        .read_index  (read_index),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .stage       (stage),
        .stage_valid (stage_valid),
        .stage_take  (stage_take)
    );

    efr_out_pipe u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .stage_valid  (stage_valid),
        .stage_take   (stage_take),
        .ram_rdata    (ram_rdata),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .event_res    (event_res),
        .frame_held   (frame_held),
        .frame_length (frame_length),
        .read_data    (read_data),
        .computed_crc (computed_crc),
        .received_crc (received_crc)
    );

endmodule

FILE: design/efr_store_ram.sv
// Frame store: single write port, single read port, registered read data.
// Depends on efr_pkg for depth and address width.
module efr_store_ram
    import efr_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] store_mem [STORE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/efr_rx_ctrl.sv
// Input decode, code registers, frame state and CRC tracking; drives the store ports.
// Depends on efr_pkg; feeds the first pipeline stage to efr_out_pipe.
module efr_rx_ctrl
    import efr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [1:0]        func,
    input  logic [7:0]        rx_byte,
    input  logic [IDX_W-1:0]  read_index,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [7:0]        ram_wdata,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr,
    output stage_t            stage,
    output logic              stage_valid,
    input  logic              stage_take
);

    logic [7:0]       start_code_reg, end_code_reg, escape_code_reg;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       tail0_reg, tail0_next, tail1_reg, tail1_next;
    logic             esc_reg, esc_next;
    logic             held_reg, held_next;
    logic             stage_valid_reg;
    stage_t           stage_reg, stage_next;
    logic             accept;
    logic             put;
    logic             rd_ok;
    logic             do_read;
    event_t           ev;
    logic [ADDR_W-1:0] put_addr;

    assign item_ready = !stage_valid_reg || stage_take;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        len_next   = len_reg;
        crc_next   = crc_reg;
        tail0_next = tail0_reg;
        tail1_next = tail1_reg;
        esc_next   = esc_reg;
        held_next  = held_reg;
        ev         = EV_ABSORBED;
        put        = 1'b0;
        rd_ok      = 1'b0;
        do_read    = 1'b0;
        put_addr   = '0;
        if (accept)
        begin
            unique case (func)
                FUNC_PUSH:
                begin
                    if (held_reg)
                    begin
                        ev = EV_DROPPED;
                    end
                    else
                    begin
                        if (len_reg >= LEN_W'(STORE_DEPTH))
                        begin
                            len_next   = '0;
                            crc_next   = '0;
                            tail0_next = '0;
                            tail1_next = '0;
                        end
                        priority if (esc_reg)
                        begin
                            put      = 1'b1;
                            esc_next = 1'b0;
                        end
                        else if (rx_byte == start_code_reg)
                        begin
                            len_next   = '0;
                            crc_next   = '0;
                            tail0_next = '0;
                            tail1_next = '0;
                        end
                        else if (rx_byte == end_code_reg)
                        begin
                            if (len_next > LEN_W'(2) && crc_next == {tail1_next, tail0_next})
                            begin
                                held_next = 1'b1;
                                ev        = EV_GOOD;
                            end
                            else
                            begin
                                ev = EV_BAD;
                            end
                        end
                        else if (rx_byte == escape_code_reg)
                        begin
                            esc_next = 1'b1;
                        end
                        else
                        begin
                            put = 1'b1;
                        end
                        if (put)
                        begin
                            put_addr = ADDR_W'(len_next);
                            if (len_next >= LEN_W'(2))
                            begin
                                crc_next = crc_feed(crc_next, tail0_next);
                            end
                            tail0_next = tail1_next;
                            tail1_next = rx_byte;
                            len_next   = len_next + LEN_W'(1);
                        end
                    end
                end
                FUNC_READ:
                begin
                    ev      = EV_READ;
                    do_read = 1'b1;
                    rd_ok   = (CMP_W'(read_index) < CMP_W'(len_reg)) &&
                              (CMP_W'(read_index) < CMP_W'(STORE_DEPTH));
                end
                FUNC_RELEASE:
                begin
                    held_next = 1'b0;
                    ev        = EV_RELEASED;
                end
                default:
                begin
                    ev = EV_ABSORBED;
                end
            endcase
        end
    end

    always_comb
    begin
        stage_next        = stage_reg;
        stage_next.ev     = ev;
        stage_next.held   = held_next;
        stage_next.length = 10'(len_next);
        stage_next.rd_ok  = rd_ok;
        stage_next.crc    = (len_next >= LEN_W'(2)) ? crc_next : 16'h0000;
        stage_next.tail   = (len_next >= LEN_W'(2)) ? {tail1_next, tail0_next} : 16'h0000;
    end

    assign ram_we    = put;
    assign ram_waddr = put_addr;
    assign ram_wdata = rx_byte;
    assign ram_re    = do_read;
    assign ram_raddr = ADDR_W'(read_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg  <= START_CODE_RST;
            end_code_reg    <= END_CODE_RST;
            escape_code_reg <= ESCAPE_CODE_RST;
            len_reg         <= '0;
            crc_reg         <= '0;
            tail0_reg       <= '0;
            tail1_reg       <= '0;
            esc_reg         <= 1'b0;
            held_reg        <= 1'b0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_START_CODE:  start_code_reg  <= cfg_data;
                    REG_END_CODE:    end_code_reg    <= cfg_data;
                    REG_ESCAPE_CODE: escape_code_reg <= cfg_data;
                    default:         start_code_reg  <= start_code_reg;
                endcase
            end
            len_reg   <= len_next;
            crc_reg   <= crc_next;
            tail0_reg <= tail0_next;
            tail1_reg <= tail1_next;
            esc_reg   <= esc_next;
            held_reg  <= held_next;
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (stage_take)
            begin
                stage_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage       = stage_reg;
    assign stage_valid = stage_valid_reg;

endmodule

FILE: design/efr_out_pipe.sv
// Output register: joins the first stage with the store read data and holds the word
// until it is taken. Depends on efr_pkg.
module efr_out_pipe
    import efr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  stage_t      stage,
    input  logic        stage_valid,
    output logic        stage_take,
    input  logic [7:0]  ram_rdata,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  event_res,
    output logic        frame_held,
    output logic [9:0]  frame_length,
    output logic [7:0]  read_data,
    output logic [15:0] computed_crc,
    output logic [15:0] received_crc
);

    logic        out_valid_reg;
    logic [2:0]  event_reg;
    logic        held_reg;
    logic [9:0]  length_reg;
    logic [7:0]  read_data_reg;
    logic [15:0] crc_reg;
    logic [15:0] tail_reg;

    assign stage_take = stage_valid && (!out_valid_reg || result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_take)
        begin
            event_reg     <= stage.ev;
            held_reg      <= stage.held;
            length_reg    <= stage.length;
            read_data_reg <= stage.rd_ok ? ram_rdata : 8'h00;
            crc_reg       <= stage.crc;
            tail_reg      <= stage.tail;
        end
    end

    assign result_valid = out_valid_reg;
    assign event_res    = event_reg;
    assign frame_held   = held_reg;
    assign frame_length = length_reg;
    assign read_data    = read_data_reg;
    assign computed_crc = crc_reg;
    assign received_crc = tail_reg;

endmodule
